// File: rtl/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types, widths and the power-of-ten table for the float to scaled
// decimal converter.
// ----------------------------------------------------------------------------
package fsd_pkg;

  // Width of the coefficient accumulator: m * 10^27 stays below 2^114.
  localparam int unsigned CoeffW = 114;
  // Width of the decimal result coefficient.
  localparam int unsigned ResW   = 96;
  // Width of a power-of-ten table entry: 10^29 stays below 2^97.
  localparam int unsigned PowW   = 100;
  // Biased exponent at which the magnitude reaches 2^96, or is NaN or infinity.
  localparam logic [7:0]  ExpErr = 8'd223;
  // Scale target: the scale is 28 less the integer digit count, and never below zero.
  localparam logic [4:0]  MaxScale = 5'd28;

  typedef struct packed {
    logic load;      // capture a new input
    logic ip_en;     // store the integer part of the magnitude
    logic d_inc;     // count one more integer digit
    logic s_set;     // fix the scale from the digit count
    logic mul_step;  // multiply the coefficient by ten
    logic res_en;    // store the final shifted coefficient
    logic out_load;  // move the finished result to the output register
  } fsd_cmd_t;

  typedef struct packed {
    logic err;        // input is NaN, infinity or too large
    logic pow_le_ip;  // current power of ten does not exceed the integer part
    logic cnt_zero;   // no multiplications by ten remain
  } fsd_sts_t;

  function automatic logic [PowW-1:0] pow10(input logic [4:0] k);
    logic [PowW-1:0] v;
    case (k)
      5'd0:  v = 100'd1;
      5'd1:  v = 100'd10;
      5'd2:  v = 100'd100;
      5'd3:  v = 100'd1000;
      5'd4:  v = 100'd10000;
      5'd5:  v = 100'd100000;
      5'd6:  v = 100'd1000000;
      5'd7:  v = 100'd10000000;
      5'd8:  v = 100'd100000000;
      5'd9:  v = 100'd1000000000;
      5'd10: v = 100'd10000000000;
      5'd11: v = 100'd100000000000;
      5'd12: v = 100'd1000000000000;
      5'd13: v = 100'd10000000000000;
      5'd14: v = 100'd100000000000000;
      5'd15: v = 100'd1000000000000000;
      5'd16: v = 100'd10000000000000000;
      5'd17: v = 100'd100000000000000000;
      5'd18: v = 100'd1000000000000000000;
      5'd19: v = 100'd10000000000000000000;
      5'd20: v = 100'd100000000000000000000;
      5'd21: v = 100'd1000000000000000000000;
      5'd22: v = 100'd10000000000000000000000;
      5'd23: v = 100'd100000000000000000000000;
      5'd24: v = 100'd1000000000000000000000000;
      5'd25: v = 100'd10000000000000000000000000;
      5'd26: v = 100'd100000000000000000000000000;
      5'd27: v = 100'd1000000000000000000000000000;
      5'd28: v = 100'd10000000000000000000000000000;
      5'd29: v = 100'd100000000000000000000000000000;
      default: v = '1;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/fsd_dpath.sv
// ----------------------------------------------------------------------------
// fsd_dpath
// Datapath: operand capture, shared binary shifter, digit counter, iterative
// multiply by ten and the output register.
// ----------------------------------------------------------------------------
module fsd_dpath (
  input  logic                  clk_i,
  input  logic [31:0]           float_bits_i,
  input  fsd_pkg::fsd_cmd_t     cmd_i,
  output fsd_pkg::fsd_sts_t     sts_o,
  output logic                  error_o,
  output logic                  negative_o,
  output logic [63:0]           coeff_low_o,
  output logic [31:0]           coeff_high_o,
  output logic [4:0]            scale_o
);
  import fsd_pkg::*;

  logic [CoeffW-1:0] c_q, c_d;
  logic signed [8:0] e_q, e_d;
  logic              neg_q, err_q;
  logic [ResW-1:0]   ip_q;
  logic [4:0]        d_q, cnt_q, s_q;
  logic [4:0]        s_calc;

  logic              error_q, negative_q;
  logic [ResW-1:0]   coeff_q;
  logic [4:0]        scale_q;

  logic [7:0]        bexp;
  logic [23:0]       mant;
  logic [8:0]        neg_amt;
  logic [ResW-1:0]   shl_res, shr_res, shift_res;
  logic [CoeffW-1:0] shr_full;

  assign bexp = float_bits_i[30:23];
  assign mant = (bexp == 8'd0) ? {1'b0, float_bits_i[22:0]} : {1'b1, float_bits_i[22:0]};

  always_comb begin
    if (bexp == 8'd0) begin
      e_d = -9'sd149;
    end else begin
      e_d = $signed({1'b0, bexp}) - 9'sd150;
    end
  end

  // One shifter serves both the integer part (c_q still holds the significand)
  // and the final coefficient. Left shifts never exceed 96 result bits.
  assign neg_amt   = 9'(-e_q);
  assign shl_res   = ResW'(c_q) << e_q[6:0];
  assign shr_full  = c_q >> neg_amt[7:0];
  assign shr_res   = shr_full[ResW-1:0];
  assign shift_res = e_q[8] ? shr_res : shl_res;

  assign c_d    = cmd_i.load ? CoeffW'(mant) : (c_q << 3) + (c_q << 1);
  assign s_calc = (d_q >= MaxScale) ? 5'd0 : MaxScale - d_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q   <= c_d;
      e_q   <= e_d;
      err_q <= (bexp >= ExpErr);
      neg_q <= float_bits_i[31] && (mant != 24'd0);
    end else if (cmd_i.mul_step) begin
      c_q <= c_d;
    end
    if (cmd_i.ip_en || cmd_i.res_en) begin
      ip_q <= shift_res;
    end
    if (cmd_i.ip_en) begin
      d_q <= 5'd1;
    end else if (cmd_i.d_inc) begin
      d_q <= d_q + 5'd1;
    end
    if (cmd_i.s_set) begin
      s_q   <= s_calc;
      cnt_q <= s_calc;
    end else if (cmd_i.mul_step) begin
      cnt_q <= cnt_q - 5'd1;
    end
    if (cmd_i.out_load) begin
      error_q    <= err_q;
      negative_q <= err_q ? 1'b0 : neg_q;
      coeff_q    <= err_q ? '0 : ip_q;
      scale_q    <= err_q ? 5'd0 : s_q;
    end
  end

  assign sts_o.err       = err_q;
  assign sts_o.pow_le_ip = (pow10(d_q) <= PowW'(ip_q));
  assign sts_o.cnt_zero  = (cnt_q == 5'd0);

  assign error_o      = error_q;
  assign negative_o   = negative_q;
  assign coeff_low_o  = coeff_q[63:0];
  assign coeff_high_o = coeff_q[95:64];
  assign scale_o      = scale_q;

endmodule

// File: rtl/fsd_ctrl.sv
// ----------------------------------------------------------------------------
// fsd_ctrl
// Controller: sequences capture, digit count, scaling and output handoff,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
module fsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  fsd_pkg::fsd_sts_t sts_i,
  output fsd_pkg::fsd_cmd_t cmd_o
);
  import fsd_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StIp    = 3'd1;
  localparam logic [2:0] StCount = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StShift = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StIp;
        end
      end
      StIp: begin
        cmd_o.ip_en = 1'b1;
        state_d     = sts_i.err ? StDone : StCount;
      end
      StCount: begin
        if (sts_i.pow_le_ip) begin
          cmd_o.d_inc = 1'b1;
        end else begin
          cmd_o.s_set = 1'b1;
          state_d     = StMul;
        end
      end
      StMul: begin
        if (sts_i.cnt_zero) begin
          state_d = StShift;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      StShift: begin
        cmd_o.res_en = 1'b1;
        state_d      = StDone;
      end
      StDone: begin
        // The output register is free once its transaction completes.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/float_to_scaled_decimal.sv
// ----------------------------------------------------------------------------
// float_to_scaled_decimal
// Converts IEEE single-precision bits to a 96-bit decimal with sign,
// coefficient and scale, truncating toward zero.
// ----------------------------------------------------------------------------
// Steps: capture the input, store the integer part, count its decimal digits,
// multiply the significand by ten once per scale digit, shift out the final
// coefficient and hand it to the output register; on error the result is handed
// over straight after the integer part. One input is converted at a time.
// The next input is taken while a finished result waits in the output register.
// Reset is asynchronous and active low and clears only the control state.
module float_to_scaled_decimal (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] float_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        error_o,
  output logic        negative_o,
  output logic [63:0] coeff_low_o,
  output logic [31:0] coeff_high_o,
  output logic [4:0]  scale_o
);
  import fsd_pkg::*;

  fsd_cmd_t cmd;
  fsd_sts_t sts;

  fsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fsd_dpath u_dpath (
    .clk_i        (clk_i),
    .float_bits_i (float_bits_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .error_o      (error_o),
    .negative_o   (negative_o),
    .coeff_low_o  (coeff_low_o),
    .coeff_high_o (coeff_high_o),
    .scale_o      (scale_o)
  );

endmodule
